@@ hdl/solve_3x3_linear_system_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 linear system solver
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SOLVE_3X3_LINEAR_SYSTEM_TOP_MACROS_SVH
`define SOLVE_3X3_LINEAR_SYSTEM_TOP_MACROS_SVH

// same-cycle implication
`define SLS_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sls check failed");

// next-cycle implication
`define SLS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sls check failed");

`endif

@@ hdl/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// Types and widths for the 3x3 linear system solver.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int XW        = 32;
  localparam int STW       = 2;
  localparam int FRAC_BITS = 16;
  localparam int PW        = 2 * XW;
  localparam int CW        = PW + 1;
  localparam int LOW       = XW + 1;
  localparam int PLW       = XW + LOW + 1;
  localparam int PRW       = XW + CW;
  localparam int SW        = PRW + 3;
  localparam int NW        = SW + FRAC_BITS;
  localparam int QW        = XW;
  localparam int DW        = NW + QW;
  localparam int NMUL      = 12;

  localparam logic signed [XW-1:0] XMAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = {1'b1, {(XW-1){1'b0}}};

  typedef enum logic [STW-1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGULAR = 2'd1,
    STAT_SAT      = 2'd2
  } sls_stat_t;

  typedef struct packed {
    logic signed [XW-1:0] a00;
    logic signed [XW-1:0] a01;
    logic signed [XW-1:0] a02;
    logic signed [XW-1:0] a10;
    logic signed [XW-1:0] a11;
    logic signed [XW-1:0] a12;
    logic signed [XW-1:0] a20;
    logic signed [XW-1:0] a21;
    logic signed [XW-1:0] a22;
    logic signed [XW-1:0] b0;
    logic signed [XW-1:0] b1;
    logic signed [XW-1:0] b2;
  } sls_in_t;

  typedef struct packed {
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] x1;
    logic signed [XW-1:0] x2;
    logic [STW-1:0]       status;
  } sls_out_t;

endpackage

@@ hdl/sls_in_if.sv @@
// ----------------------------------------------------------------------------
// sls_in_if
// Request channel carrying one matrix and right-hand vector.
// ----------------------------------------------------------------------------
interface sls_in_if;
  import sls_pkg::*;

  logic    valid;
  logic    ready;
  sls_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sls_out_if.sv @@
// ----------------------------------------------------------------------------
// sls_out_if
// Result channel carrying one solution vector and its status.
// ----------------------------------------------------------------------------
interface sls_out_if;
  import sls_pkg::*;

  logic     valid;
  logic     ready;
  sls_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/solve_3x3_linear_system_top.sv @@
// ----------------------------------------------------------------------------
// solve_3x3_linear_system_top
// Sustains one request per cycle while the result side is not stalled.
// Seven arithmetic stages form products, cofactors, determinant, numerators,
// magnitudes and overflow flags, then 32 restoring-division stages produce one quotient bit each.
// A stall on the result side freezes the whole pipeline.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module solve_3x3_linear_system_top (
  input logic       clk,
  input logic       rst,
  sls_in_if.sink    sys,
  sls_out_if.source sol
);
  import sls_pkg::*;

  logic en;

  logic                 v1;
  logic signed [PW-1:0] pm [0:8];
  logic signed [PW-1:0] pn [0:8];
  logic signed [XW-1:0] ra1 [0:2];
  logic signed [XW-1:0] rb1 [0:2];

  logic                 v2;
  logic signed [CW-1:0] cf [0:8];
  logic signed [XW-1:0] ra2 [0:2];
  logic signed [XW-1:0] rb2 [0:2];

  logic signed [XW-1:0] ma [0:NMUL-1];
  logic signed [CW-1:0] mc [0:NMUL-1];

  logic                  v3;
  logic signed [PLW-1:0] plo [0:NMUL-1];
  logic signed [PW-1:0]  phi [0:NMUL-1];

  logic                  v4;
  logic signed [PRW-1:0] prod [0:NMUL-1];

  logic                 v5;
  logic signed [SW-1:0] sm [0:3];

  logic          v6;
  logic [SW-1:0] dm6;
  logic          dz6;
  logic [NW-1:0] nm6 [0:2];
  logic          ng6 [0:2];

  logic          dv_v   [0:QW];
  logic [SW-1:0] dv_dm  [0:QW];
  logic          dv_dz  [0:QW];
  logic [NW-1:0] dv_rem [0:QW][0:2];
  logic [QW-1:0] dv_q   [0:QW][0:2];
  logic          dv_ng  [0:QW][0:2];
  logic          dv_big [0:QW][0:2];

  logic     ov;
  sls_out_t od;

  assign en        = !ov || sol.ready;
  assign sys.ready = en;
  assign sol.valid = ov;
  assign sol.data  = od;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      v1 <= sys.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      ov <= dv_v[QW];
    end
  end

  // products of the 2x2 minors, positive and negative terms
  always_ff @(posedge clk) begin
    if (en) begin
      pm[0] <= sys.data.a11 * sys.data.a22;  pn[0] <= sys.data.a12 * sys.data.a21;
      pm[1] <= sys.data.a12 * sys.data.a20;  pn[1] <= sys.data.a10 * sys.data.a22;
      pm[2] <= sys.data.a10 * sys.data.a21;  pn[2] <= sys.data.a11 * sys.data.a20;
      pm[3] <= sys.data.a02 * sys.data.a21;  pn[3] <= sys.data.a01 * sys.data.a22;
      pm[4] <= sys.data.a00 * sys.data.a22;  pn[4] <= sys.data.a02 * sys.data.a20;
      pm[5] <= sys.data.a01 * sys.data.a20;  pn[5] <= sys.data.a00 * sys.data.a21;
      pm[6] <= sys.data.a01 * sys.data.a12;  pn[6] <= sys.data.a02 * sys.data.a11;
      pm[7] <= sys.data.a02 * sys.data.a10;  pn[7] <= sys.data.a00 * sys.data.a12;
      pm[8] <= sys.data.a00 * sys.data.a11;  pn[8] <= sys.data.a01 * sys.data.a10;
      ra1[0] <= sys.data.a00;
      ra1[1] <= sys.data.a01;
      ra1[2] <= sys.data.a02;
      rb1[0] <= sys.data.b0;
      rb1[1] <= sys.data.b1;
      rb1[2] <= sys.data.b2;
    end
  end

  // cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        cf[k] <= CW'(pm[k]) - CW'(pn[k]);
      end
      ra2 <= ra1;
      rb2 <= rb1;
    end
  end

  // determinant terms, then adjugate rows times b
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma[k] = ra2[k];
      mc[k] = cf[k];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ma[3 + 3 * i + j] = rb2[j];
        mc[3 + 3 * i + j] = cf[3 * j + i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NMUL; k++) begin
        plo[k] <= ma[k] * $signed({1'b0, mc[k][LOW-1:0]});
        phi[k] <= ma[k] * $signed(mc[k][CW-1:LOW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NMUL; k++) begin
        prod[k] <= PRW'(plo[k]) + (PRW'(phi[k]) <<< LOW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 4; s++) begin
        sm[s] <= SW'(prod[3 * s]) + SW'(prod[3 * s + 1]) + SW'(prod[3 * s + 2]);
      end
    end
  end

  // magnitudes, signs, fraction scaling
  always_ff @(posedge clk) begin
    if (en) begin
      dm6 <= sm[0][SW-1] ? SW'(-sm[0]) : SW'(sm[0]);
      dz6 <= (sm[0] == '0);
      for (int i = 0; i < 3; i++) begin
        nm6[i] <= (sm[i+1][SW-1] ? NW'(SW'(-sm[i+1])) : NW'(SW'(sm[i+1]))) << FRAC_BITS;
        ng6[i] <= sm[i+1][SW-1] ^ sm[0][SW-1];
      end
    end
  end

  // overflow check ahead of the bit stages
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_dm[0] <= dm6;
      dv_dz[0] <= dz6;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= nm6[i];
        dv_q[0][i]   <= '0;
        dv_ng[0][i]  <= ng6[i];
        dv_big[0][i] <= DW'(nm6[i]) >= (DW'(dm6) << QW);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [DW-1:0] dsh;
    logic          take [0:2];

    assign dsh = DW'(dv_dm[j]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = DW'(dv_rem[j][i]) >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_dm[j+1] <= dv_dm[j];
        dv_dz[j+1] <= dv_dz[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i]  <= take[i] ? NW'(DW'(dv_rem[j][i]) - dsh) : dv_rem[j][i];
          dv_q[j+1][i]    <= dv_q[j][i] | (QW'(take[i]) << K);
          dv_ng[j+1][i]   <= dv_ng[j][i];
          dv_big[j+1][i]  <= dv_big[j][i];
        end
      end
    end
  end

  // sign, clamp, status
  logic signed [XW-1:0] xv  [0:2];
  logic                 sat [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_ng[QW][i]) begin
        sat[i] = dv_big[QW][i] || (dv_q[QW][i] > QW'(XMIN));
        xv[i]  = sat[i] ? XMIN : XW'(-dv_q[QW][i]);
      end else begin
        sat[i] = dv_big[QW][i] || (dv_q[QW][i] > QW'(XMAX));
        xv[i]  = sat[i] ? XMAX : XW'(dv_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_dz[QW]) begin
        od.x0     <= '0;
        od.x1     <= '0;
        od.x2     <= '0;
        od.status <= STAT_SINGULAR;
      end else begin
        od.x0     <= xv[0];
        od.x1     <= xv[1];
        od.x2     <= xv[2];
        od.status <= (sat[0] || sat[1] || sat[2]) ? STAT_SAT : STAT_OK;
      end
    end
  end

endmodule

@@ hdl/sls_check.sv @@
// ----------------------------------------------------------------------------
// sls_check
// Port-level checks for the 3x3 linear system solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "solve_3x3_linear_system_top_macros.svh"

module sls_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [sls_pkg::XW-1:0]  x0,
  input logic signed [sls_pkg::XW-1:0]  x1,
  input logic signed [sls_pkg::XW-1:0]  x2,
  input logic        [sls_pkg::STW-1:0] status
);
  import sls_pkg::*;

  `SLS_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(x0) && $stable(x1) && $stable(x2) && $stable(status))
  `SLS_HOLDS(a_accept, !out_valid, in_ready)
  `SLS_HOLDS(a_sing_zero, out_valid && status == STAT_SINGULAR, x0 == '0 && x1 == '0 && x2 == '0)
  `SLS_HOLDS(a_sat_clamp, out_valid && status == STAT_SAT, x0 == XMAX || x0 == XMIN || x1 == XMAX || x1 == XMIN || x2 == XMAX || x2 == XMIN)

  // accept an offered request while no result is waiting
  `SLS_HOLDS(a_ready_idle, in_valid && !out_valid, in_ready)

endmodule

bind solve_3x3_linear_system_top sls_check u_sls_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sys.valid),
  .in_ready  (sys.ready),
  .out_valid (sol.valid),
  .out_ready (sol.ready),
  .x0        (sol.data.x0),
  .x1        (sol.data.x1),
  .x2        (sol.data.x2),
  .status    (sol.data.status)
);
